FILE: design/qasm_pkg.sv
// ----------------------------------------------------------------------------
// qasm_pkg: shared types and constants for the binary128 add/sub/mul core
// Holds the format constants, the operation codes and the record that
// carries an unnormalized result from a datapath into the normalizer.
// ----------------------------------------------------------------------------
package qasm_pkg;

	// Binary128 format.
	localparam int EXP_W    = 15;
	localparam int FRAC_W   = 112;
	localparam int MANT_W   = FRAC_W + 1;
	localparam int EXP_BIAS = 16383;
	localparam int EXP_MAX  = 32767;

	// Guard bits below the mantissa and the normalized leading-bit position.
	localparam int GUARD_W  = 12;
	localparam int NORM_POS = 124;

	// Internal exponent width (signed), wide enough for ea + eb - bias.
	localparam int XEXP_W = 18;

	// Multiplier limb split: four limbs of 29 bits cover the 113-bit mantissa.
	localparam int LIMB_W    = 29;
	localparam int NUM_LIMBS = 4;
	localparam int PROD_SHR  = 100;

	// Operation codes; the spare code behaves as multiply.
	localparam logic [1:0] ACT_ADD     = 2'd0;
	localparam logic [1:0] ACT_SUB     = 2'd1;
	localparam logic [1:0] ACT_MUL     = 2'd2;
	localparam logic [1:0] ACT_MUL_ALT = 2'd3;

	// Unnormalized result: magnitude, exponent of bit 124 and sign.
	typedef struct packed {
		logic [127:0]              frc;
		logic signed [XEXP_W-1:0]  exc;
		logic                      sgn;
	} path_t;

endpackage

FILE: design/binary128_add_sub_mul_unit_core.sv
// ----------------------------------------------------------------------------
// binary128_add_sub_mul_unit_core: pipelined binary128 add/sub/mul
// Top level: operation decode, valid and stall control, path merge.
// ----------------------------------------------------------------------------
// Usage:
//   Operations enter on the s_axis channel; one transaction carries the
//   action code and both operands. Each operation produces exactly one
//   transaction on the m_axis channel with the binary128 result.
//   From acceptance until the result can be taken on m_axis, an operation
//   passes 5 multiplier stages (partial products and a registered adder
//   tree) and 2 normalize/round stages; the add path takes 3 stages and
//   is delayed to match. One operation is accepted every cycle unless stalled.
//   The whole pipeline advances together: while m_axis holds a result
//   that is not taken, every stage holds and s_axis_tready is low, so no
//   transaction is lost or repeated. Empty stages are filled while the
//   output is idle.
//   Reset clears all valid bits; the pipeline is empty and ready at once.
//   Results below the normal range flush to +0, overflow gives signed
//   infinity, and NaN or infinity operands get no special treatment.
// ----------------------------------------------------------------------------
module binary128_add_sub_mul_unit_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [1:0] action, [65:2] a_hi, [129:66] a_lo, [193:130] b_hi,
	// [257:194] b_lo, [263:258] zero
	input  logic [263:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [63:0] result_hi, [127:64] result_lo
	output logic [127:0] m_axis_tdata
);
	import qasm_pkg::*;

	localparam int DEPTH = 7;

	logic [1:0]   action;
	logic [63:0]  a_hi, a_lo, b_hi, b_lo, b_hi_eff;
	logic         adv;
	logic [DEPTH-1:0] vld_q;
	logic [4:0]   ismul_q;
	path_t        add_res, mul_res, add_s4, add_s5, sel_res;
	logic [127:0] result;

	// Unpack the input transaction; subtract flips the sign of b.
	always_comb begin
		action   = s_axis_tdata[1:0];
		a_hi     = s_axis_tdata[65:2];
		a_lo     = s_axis_tdata[129:66];
		b_hi     = s_axis_tdata[193:130];
		b_lo     = s_axis_tdata[257:194];
		b_hi_eff = (action == ACT_SUB) ? {~b_hi[63], b_hi[62:0]} : b_hi;
	end

	// The pipeline advances when the output register is empty or taken.
	assign adv           = !vld_q[DEPTH-1] || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid};
		end
	end

	// Operation kind travels alongside the datapaths.
	always_ff @(posedge clk) begin
		if (adv) begin
			ismul_q <= {ismul_q[3:0], (action == ACT_MUL) || (action == ACT_MUL_ALT)};
		end
	end

	qasm_add u_add (
		.clk  (clk),
		.en   (adv),
		.a_hi (a_hi),
		.a_lo (a_lo),
		.b_hi (b_hi_eff),
		.b_lo (b_lo),
		.res  (add_res)
	);

	qasm_mul u_mul (
		.clk  (clk),
		.en   (adv),
		.a_hi (a_hi),
		.a_lo (a_lo),
		.b_hi (b_hi),
		.b_lo (b_lo),
		.res  (mul_res)
	);

	// Delay the add result to line up with the multiplier.
	always_ff @(posedge clk) begin
		if (adv) begin
			add_s4 <= add_res;
			add_s5 <= add_s4;
		end
	end

	assign sel_res = ismul_q[4] ? mul_res : add_s5;

	qasm_norm u_norm (
		.clk    (clk),
		.en     (adv),
		.src    (sel_res),
		.result (result)
	);

	assign m_axis_tdata = {result[63:0], result[127:64]};

`ifndef SYNTHESIS
	// An accepted transaction enters the first stage.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> vld_q[0])
		else $error("accepted transaction did not enter the pipeline");

	// Infinity always carries a zero fraction.
	a_inf_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[62:48] == 15'h7fff) |->
		(m_axis_tdata[47:0] == 48'd0 && m_axis_tdata[127:64] == 64'd0))
		else $error("infinity result with nonzero fraction");

	// No subnormals: a zero exponent means the result is +0.
	a_zero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[62:48] == 15'd0) |->
		(m_axis_tdata[63:48] == 16'd0 && m_axis_tdata[47:0] == 48'd0 &&
		m_axis_tdata[127:64] == 64'd0))
		else $error("zero exponent with nonzero sign or fraction");
`endif

endmodule

FILE: design/qasm_add.sv
// ----------------------------------------------------------------------------
// qasm_add: three-stage add/subtract datapath
// Orders the operands by magnitude, aligns the smaller one and adds or
// subtracts the mantissas carrying 12 guard bits.
// ----------------------------------------------------------------------------
module qasm_add (
	input  logic              clk,
	input  logic              en,
	input  logic [63:0]       a_hi,
	input  logic [63:0]       a_lo,
	input  logic [63:0]       b_hi,
	input  logic [63:0]       b_lo,
	output qasm_pkg::path_t   res
);
	import qasm_pkg::*;

	localparam int FW = MANT_W + GUARD_W;

	logic [EXP_W-1:0]  ea, eb, ediff;
	logic [MANT_W-1:0] ma, mb;
	logic              swap;
	logic [7:0]        shamt;

	logic [FW-1:0]     fbig_s1, fsml_s1;
	logic [EXP_W-1:0]  ebig_s1;
	logic              sbig_s1, sub_s1;
	logic [7:0]        shamt_s1;

	logic [FW-1:0]     fbig_s2, fsml_s2;
	logic [EXP_W-1:0]  ebig_s2;
	logic              sbig_s2, sub_s2;

	logic [FW:0]       sum;
	path_t             res_s3;

	// Stage 1: unpack, order by magnitude and work out the alignment shift.
	always_comb begin
		ea    = a_hi[62:48];
		eb    = b_hi[62:48];
		ma    = {(ea != '0), a_hi[47:0], a_lo};
		mb    = {(eb != '0), b_hi[47:0], b_lo};
		swap  = (eb > ea) || ((eb == ea) && (mb > ma));
		ediff = swap ? (eb - ea) : (ea - eb);
		shamt = (ediff >= EXP_W'(128)) ? 8'd128 : ediff[7:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fbig_s1  <= swap ? {mb, GUARD_W'(0)} : {ma, GUARD_W'(0)};
			fsml_s1  <= swap ? {ma, GUARD_W'(0)} : {mb, GUARD_W'(0)};
			ebig_s1  <= swap ? eb : ea;
			sbig_s1  <= swap ? b_hi[63] : a_hi[63];
			sub_s1   <= a_hi[63] ^ b_hi[63];
			shamt_s1 <= shamt;
		end
	end

	// Stage 2: shift the smaller mantissa right; far shifts clear it.
	always_ff @(posedge clk) begin
		if (en) begin
			fbig_s2 <= fbig_s1;
			fsml_s2 <= shamt_s1[7] ? '0 : (fsml_s1 >> shamt_s1[6:0]);
			ebig_s2 <= ebig_s1;
			sbig_s2 <= sbig_s1;
			sub_s2  <= sub_s1;
		end
	end

	// Stage 3: magnitude add or subtract.
	always_comb begin
		if (sub_s2) begin
			sum = {1'b0, fbig_s2 - fsml_s2};
		end else begin
			sum = {1'b0, fbig_s2} + {1'b0, fsml_s2};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3.frc <= 128'(sum);
			res_s3.exc <= XEXP_W'(ebig_s2);
			res_s3.sgn <= sbig_s2;
		end
	end

	assign res = res_s3;

endmodule

FILE: design/qasm_mul.sv
// ----------------------------------------------------------------------------
// qasm_mul: five-stage 113 x 113 mantissa multiplier
// Sixteen 29 x 29 partial products are registered, then summed by a
// registered tree; the product shifted right by 100 leaves the last stage.
// ----------------------------------------------------------------------------
module qasm_mul (
	input  logic              clk,
	input  logic              en,
	input  logic [63:0]       a_hi,
	input  logic [63:0]       a_lo,
	input  logic [63:0]       b_hi,
	input  logic [63:0]       b_lo,
	output qasm_pkg::path_t   res
);
	import qasm_pkg::*;

	localparam int PAD_W  = LIMB_W * NUM_LIMBS;
	localparam int PP_W   = 2 * LIMB_W;
	localparam int PR_W   = PP_W + LIMB_W + 1;
	localparam int ROW_W  = PR_W + PP_W;
	localparam int HALF_W = ROW_W + LIMB_W + 1;
	localparam int PROD_W = HALF_W + PP_W;

	logic [EXP_W-1:0]  ea, eb;
	logic [PAD_W-1:0]  ma, mb;

	logic [PP_W-1:0]   pp_s1  [NUM_LIMBS][NUM_LIMBS];
	logic [PR_W-1:0]   pr_s2  [NUM_LIMBS][2];
	logic [ROW_W-1:0]  row_s3 [NUM_LIMBS];
	logic [HALF_W-1:0] half_s4 [2];
	logic [PROD_W-1:0] prod;
	path_t             res_s5;

	logic signed [XEXP_W-1:0] exc_s1, exc_s2, exc_s3, exc_s4;
	logic                     sgn_s1, sgn_s2, sgn_s3, sgn_s4;

	// Unpack mantissas with the hidden bit, padded to whole limbs.
	always_comb begin
		ea = a_hi[62:48];
		eb = b_hi[62:48];
		ma = PAD_W'({(ea != '0), a_hi[47:0], a_lo});
		mb = PAD_W'({(eb != '0), b_hi[47:0], b_lo});
	end

	// Stage 1: partial products and the product exponent.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_LIMBS; i++) begin
				for (int j = 0; j < NUM_LIMBS; j++) begin
					pp_s1[i][j] <= PP_W'(ma[i*LIMB_W +: LIMB_W]) *
						PP_W'(mb[j*LIMB_W +: LIMB_W]);
				end
			end
			exc_s1 <= XEXP_W'(ea) + XEXP_W'(eb) - XEXP_W'(EXP_BIAS);
			sgn_s1 <= a_hi[63] ^ b_hi[63];
		end
	end

	// Stage 2: pair neighboring products within each row.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_LIMBS; i++) begin
				for (int k = 0; k < 2; k++) begin
					pr_s2[i][k] <= PR_W'(pp_s1[i][2*k]) +
						(PR_W'(pp_s1[i][2*k+1]) << LIMB_W);
				end
			end
			exc_s2 <= exc_s1;
			sgn_s2 <= sgn_s1;
		end
	end

	// Stage 3: complete each row.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_LIMBS; i++) begin
				row_s3[i] <= ROW_W'(pr_s2[i][0]) + (ROW_W'(pr_s2[i][1]) << PP_W);
			end
			exc_s3 <= exc_s2;
			sgn_s3 <= sgn_s2;
		end
	end

	// Stage 4: pair the rows.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 2; k++) begin
				half_s4[k] <= HALF_W'(row_s3[2*k]) + (HALF_W'(row_s3[2*k+1]) << LIMB_W);
			end
			exc_s4 <= exc_s3;
			sgn_s4 <= sgn_s3;
		end
	end

	// Stage 5: final sum, keep product bits 227..100.
	assign prod = PROD_W'(half_s4[0]) + (PROD_W'(half_s4[1]) << PP_W);

	always_ff @(posedge clk) begin
		if (en) begin
			res_s5.frc <= prod[PROD_SHR +: 128];
			res_s5.exc <= exc_s4;
			res_s5.sgn <= sgn_s4;
		end
	end

	assign res = res_s5;

endmodule

FILE: design/qasm_norm.sv
// ----------------------------------------------------------------------------
// qasm_norm: two-stage normalize, round and pack
// Finds the leading one, moves it to bit 124, rounds half up on the
// magnitude and handles overflow to infinity and flush to zero.
// ----------------------------------------------------------------------------
module qasm_norm (
	input  logic              clk,
	input  logic              en,
	input  qasm_pkg::path_t   src,
	output logic [127:0]      result
);
	import qasm_pkg::*;

	localparam int GRP_W  = 16;
	localparam int NUM_GRP = 128 / GRP_W;

	logic [NUM_GRP-1:0]   grp_nz;
	logic [2:0]           grp_sel;
	logic [GRP_W-1:0]     grp_bits;
	logic [3:0]           bit_sel;

	path_t                src_s1;
	logic [6:0]           pos_s1;
	logic                 nz_s1;

	logic [127:0]         frc_n;
	logic signed [18:0]   exc_n;
	logic [127:0]         packed_res;
	logic [127:0]         result_s2;

	// Stage 1: leading-one search, first over 16-bit groups, then inside.
	always_comb begin
		for (int g = 0; g < NUM_GRP; g++) begin
			grp_nz[g] = |src.frc[g*GRP_W +: GRP_W];
		end
		grp_sel = '0;
		for (int g = 0; g < NUM_GRP; g++) begin
			if (grp_nz[g]) begin
				grp_sel = 3'(g);
			end
		end
		grp_bits = src.frc[grp_sel*GRP_W +: GRP_W];
		bit_sel = '0;
		for (int b = 0; b < GRP_W; b++) begin
			if (grp_bits[b]) begin
				bit_sel = 4'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			src_s1 <= src;
			pos_s1 <= {grp_sel, bit_sel};
			nz_s1  <= |grp_nz;
		end
	end

	// Stage 2: normalizing shift, exponent adjust, round and pack.
	always_comb begin
		if (pos_s1 > 7'(NORM_POS)) begin
			frc_n = src_s1.frc >> (pos_s1 - 7'(NORM_POS));
		end else begin
			frc_n = src_s1.frc << (7'(NORM_POS) - pos_s1);
		end
		exc_n = 19'(src_s1.exc) + 19'(pos_s1) - 19'(NORM_POS);
		if (!nz_s1 || exc_n <= 19'sd0) begin
			packed_res = '0;
		end else if (exc_n >= 19'(EXP_MAX)) begin
			packed_res = {src_s1.sgn, EXP_W'(EXP_MAX), FRAC_W'(0)};
		end else begin
			packed_res = {src_s1.sgn, exc_n[EXP_W-1:0],
				frc_n[NORM_POS-1 -: FRAC_W]} + 128'(frc_n[GUARD_W-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_s2 <= packed_res;
		end
	end

	assign result = result_s2;

endmodule
